[design/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg
// Types and character constants shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Input word: a text character or an end-of-line marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       overflow;
        logic       last;
    } t_out_item;

    // Work handed from the classifier to the output side.
    typedef struct packed {
        logic       keep_slash;
        logic       keep_char;
        logic       line_end;
        logic [7:0] ch;
    } t_cmd;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[design/ccs_front.sv]
// ----------------------------------------------------------------------------
// ccs_front
// Classifier: tracks comment, string and held-slash state and turns each
// accepted word that keeps text or ends a line into a command for the output side.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ccs_pkg::t_in_item i_item,
    output ccs_pkg::t_cmd     o_cmd,
    output logic              o_cmd_vld
);
    import ccs_pkg::*;

    logic r_in_block, n_in_block;
    logic r_in_quote, n_in_quote;
    logic r_slash_held, n_slash_held;
    logic r_star_held, n_star_held;
    logic r_skip_rest, n_skip_rest;
    logic r_prev_bs, n_prev_bs;
    logic do_plain;
    t_cmd cmd;

    always_comb begin
        n_in_block   = r_in_block;
        n_in_quote   = r_in_quote;
        n_slash_held = r_slash_held;
        n_star_held  = r_star_held;
        n_skip_rest  = r_skip_rest;
        n_prev_bs    = r_prev_bs;
        do_plain     = 1'b0;
        cmd          = '0;
        cmd.ch       = i_item.ch;
        if (i_accept) begin
            if (i_item.kind) begin
                cmd.keep_slash = r_slash_held;
                cmd.line_end   = 1'b1;
                n_in_quote     = 1'b0;
                n_slash_held   = 1'b0;
                n_star_held    = 1'b0;
                n_skip_rest    = 1'b0;
                n_prev_bs      = 1'b0;
            end else begin
                n_prev_bs = (i_item.ch == CH_BSLASH);
                if (r_skip_rest) begin
                    // Rest of the line belongs to a line comment.
                end else if (r_in_block) begin
                    if (r_star_held && i_item.ch == CH_SLASH) begin
                        n_in_block  = 1'b0;
                        n_star_held = 1'b0;
                    end else begin
                        n_star_held = (i_item.ch == CH_STAR);
                    end
                end else if (r_slash_held) begin
                    n_slash_held = 1'b0;
                    if (i_item.ch == CH_STAR) begin
                        n_in_block  = 1'b1;
                        n_star_held = 1'b0;
                    end else if (i_item.ch == CH_SLASH) begin
                        n_skip_rest = 1'b1;
                    end else begin
                        cmd.keep_slash = 1'b1;
                        do_plain       = 1'b1;
                    end
                end else begin
                    do_plain = 1'b1;
                end

                if (do_plain) begin
                    if (i_item.ch == CH_QUOTE && !r_prev_bs) begin
                        n_in_quote    = !r_in_quote;
                        cmd.keep_char = 1'b1;
                    end else if (!r_in_quote && i_item.ch == CH_SLASH) begin
                        n_slash_held = 1'b1;
                    end else begin
                        cmd.keep_char = 1'b1;
                    end
                end
            end
        end
    end

    assign o_cmd     = cmd;
    assign o_cmd_vld = i_accept && (cmd.keep_slash || cmd.keep_char || cmd.line_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block   <= 1'b0;
            r_in_quote   <= 1'b0;
            r_slash_held <= 1'b0;
            r_star_held  <= 1'b0;
            r_skip_rest  <= 1'b0;
            r_prev_bs    <= 1'b0;
        end else begin
            r_in_block   <= n_in_block;
            r_in_quote   <= n_in_quote;
            r_slash_held <= n_slash_held;
            r_star_held  <= n_star_held;
            r_skip_rest  <= n_skip_rest;
            r_prev_bs    <= n_prev_bs;
        end
    end

endmodule

[design/ccs_fifo.sv]
// ----------------------------------------------------------------------------
// ccs_fifo
// Short command queue between the classifier and the output side.
// ----------------------------------------------------------------------------
module ccs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ccs_pkg::t_cmd i_wr_data,
    input  logic          i_rd,
    output ccs_pkg::t_cmd o_rd_data,
    output logic          o_vld,
    output logic          o_full
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_vld     = (r_count != '0);
    assign o_rd_data = r_store[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_vld;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/ccs_back.sv]
// ----------------------------------------------------------------------------
// ccs_back
// Output side: holds whitespace runs in a buffer memory, flushes them ahead
// of kept characters and drives the result queue through two register stages.
// ----------------------------------------------------------------------------
module ccs_back #(
    parameter int RUN_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccs_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_vld,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output ccs_pkg::t_out_item o_result
);
    import ccs_pkg::*;

    localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

    logic [7:0]       r_run_mem [RUN_DEPTH];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_run_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_run_ov;
    logic             r_slash_done;
    logic             r_char_done;

    // Stage A: issued result, character may still come from the memory read.
    logic             r_a_vld;
    logic             r_a_mem;
    logic [7:0]       r_a_char;
    logic             r_a_le;
    logic             r_a_ov;
    logic             r_a_last;

    logic             r_out_vld;
    t_out_item        r_out;

    logic             out_free;
    logic             a_free;
    logic             go;
    logic             in_slash;
    logic             in_char;
    logic             in_eol;
    logic [7:0]       cur_c;
    logic             cur_ws;
    logic             flushing;
    logic             later_emit;
    logic             cmd_done;
    logic             emit;
    logic             ws_store;

    assign out_free = !r_out_vld || i_pop;
    assign a_free   = !r_a_vld || out_free;
    assign go       = i_cmd_vld && a_free;

    assign in_slash = i_cmd.keep_slash && !r_slash_done;
    assign in_char  = !in_slash && i_cmd.keep_char && !r_char_done;
    assign in_eol   = !in_slash && !in_char;
    assign cur_c    = in_slash ? CH_SLASH : i_cmd.ch;
    assign cur_ws   = is_ws(cur_c);
    assign flushing = !in_eol && !cur_ws && (r_idx < r_run_count);
    assign ws_store = go && !in_eol && cur_ws;

    // Whether a later step of the same command still produces a result.
    assign later_emit = in_slash ? ((i_cmd.keep_char && !is_ws(i_cmd.ch)) || i_cmd.line_end)
                                 : (in_char && i_cmd.line_end);
    assign cmd_done   = !flushing
                      && (in_eol
                          || (in_slash && !i_cmd.keep_char && !i_cmd.line_end)
                          || (in_char && !i_cmd.line_end));
    assign emit       = go && (in_eol || !cur_ws);
    assign o_cmd_pop  = go && cmd_done;

    always_ff @(posedge i_clk) begin
        if (ws_store && (r_run_count < CNT_W'(RUN_DEPTH))) begin
            r_run_mem[r_run_count[ADDR_W-1:0]] <= cur_c;
        end
        if (go && flushing) begin
            r_rd_data <= r_run_mem[r_idx[ADDR_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_a_mem  <= flushing;
            r_a_char <= in_eol ? 8'h00 : cur_c;
            r_a_le   <= in_eol;
            r_a_ov   <= r_run_ov;
            r_a_last <= !flushing && (in_eol || !later_emit);
        end
        if (out_free && r_a_vld) begin
            r_out.out_char <= r_a_mem ? r_rd_data : r_a_char;
            r_out.line_end <= r_a_le;
            r_out.overflow <= r_a_ov;
            r_out.last     <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count  <= '0;
            r_idx        <= '0;
            r_run_ov     <= 1'b0;
            r_slash_done <= 1'b0;
            r_char_done  <= 1'b0;
            r_a_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (emit) begin
                r_a_vld <= 1'b1;
            end else if (out_free) begin
                r_a_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_a_vld;
            end

            if (ws_store) begin
                if (r_run_count < CNT_W'(RUN_DEPTH)) begin
                    r_run_count <= r_run_count + 1'b1;
                end else begin
                    r_run_ov <= 1'b1;
                end
            end else if (go && flushing) begin
                r_idx <= r_idx + 1'b1;
            end else if (emit) begin
                // A kept character or a line end closes the current run.
                r_run_count <= '0;
                r_run_ov    <= 1'b0;
                r_idx       <= '0;
            end

            if (go && !flushing) begin
                if (cmd_done) begin
                    r_slash_done <= 1'b0;
                    r_char_done  <= 1'b0;
                end else if (in_slash) begin
                    r_slash_done <= 1'b1;
                end else if (in_char) begin
                    r_char_done <= 1'b1;
                end
            end
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule

[design/c_comment_stripper.sv]
// A kept character passes the command queue, stage A and the output register, whose
// value is the head of the result queue, when the output side is idle and no whitespace
// run is held. The output side gives one result per cycle while results are popped; a
// character that flushes a held run of whitespace bytes first emits each held byte, and
// the QUEUE_DEPTH-entry command queue lets input continue meanwhile. Reset clears all
// control state; the run buffer contents are left as they are, needing no clearing pass.
// ----------------------------------------------------------------------------
// c_comment_stripper
// Streaming C comment stripper with trailing whitespace trimming.
// ----------------------------------------------------------------------------
module c_comment_stripper #(
    parameter int RUN_DEPTH   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ccs_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ccs_pkg::t_out_item o_result
);
    import ccs_pkg::*;

    t_cmd front_cmd;
    logic front_cmd_vld;
    t_cmd head_cmd;
    logic head_vld;
    logic head_pop;
    logic accept;

    assign accept = push && !full;

    ccs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_cmd     (front_cmd),
        .o_cmd_vld (front_cmd_vld)
    );

    ccs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_cmd_vld),
        .i_wr_data (front_cmd),
        .i_rd      (head_pop),
        .o_rd_data (head_cmd),
        .o_vld     (head_vld),
        .o_full    (full)
    );

    ccs_back #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_cmd_vld (head_vld),
        .o_cmd_pop (head_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
